>>> rtl/bbsa_pkg.sv
package bbsa_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int STRIDE     = MAX_WIDTH + 1;
	localparam int DEPTH      = (MAX_WIDTH + 1) * (MAX_HEIGHT + 1);
	localparam int ADDR_W     = $clog2(DEPTH);

	localparam int ENTRY_W    = 20;
	localparam int ROWSUM_W   = 14;
	localparam int PIX_W      = 8;
	localparam int COORD_W    = 6;
	localparam int DIM_W      = 7;
	localparam int EXT_W      = DIM_W + 1;
	localparam int RAD_W      = 6;
	localparam int SUM_W      = ENTRY_W + 2;
	localparam int DVD_W      = SUM_W - 1;
	localparam int AREA_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int Q_W        = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Corners of the window in the order they are fetched.
	localparam logic [1:0] C_Y1X1 = 2'd0;
	localparam logic [1:0] C_Y0X1 = 2'd1;
	localparam logic [1:0] C_Y1X0 = 2'd2;
	localparam logic [1:0] C_Y0X0 = 2'd3;

	typedef struct packed {
		logic       clr;
		logic       capture;
		logic       ld_wr;
		logic       rd_chk;
		logic       rd_mem;
		logic [1:0] corner;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic rd_err;
		logic div_done;
		logic out_free;
	} sts_t;

	function automatic logic [ADDR_W-1:0] addr_of(input logic [DIM_W-1:0] row,
		input logic [DIM_W-1:0] col);
		addr_of = ADDR_W'(row) * ADDR_W'(STRIDE) + ADDR_W'(col);
	endfunction

endpackage

>>> rtl/bbsa_ram.sv
module bbsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/bbsa_div.sv
module bbsa_div import bbsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [AREA_W-1:0] divisor,
	output logic [Q_W-1:0]    quotient,
	output logic              done
);

	localparam int DSR_W = AREA_W + Q_W - 1;
	localparam int CNT_W = $clog2(Q_W);

	logic [DVD_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [Q_W-1:0]   q_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;

	// A dividend of 256 times the divisor or more leaves every step taking its
	// subtraction, so the quotient saturates at 255 by itself.
	assign ge = rem_q >= DVD_W'(dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsr_q <= DSR_W'(divisor) << (Q_W - 1);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - DVD_W'(dsr_q);
			end
			dsr_q <= dsr_q >> 1;
			q_q   <= {q_q[Q_W-2:0], ge};
		end
	end

	assign quotient = q_q;
	assign done     = done_q;

	a_done_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("divider finished without a done pulse");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

endmodule

>>> rtl/bbsa_ctrl.sv
module bbsa_ctrl import bbsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic req_type,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_LD_WR  = 3'd2;
	localparam logic [2:0] S_RD_CHK = 3'd3;
	localparam logic [2:0] S_RD_MEM = 3'd4;
	localparam logic [2:0] S_DIV    = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q, state_d;
	logic [1:0] corner_q, corner_d;

	always_comb begin
		state_d  = state_q;
		corner_d = corner_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.capture = 1'b1;
				s_tready    = 1'b1;
				if (s_tvalid) begin
					state_d = (req_type == REQ_READ) ? S_RD_CHK : S_LD_WR;
				end
			end
			S_LD_WR: begin
				cmd.ld_wr = 1'b1;
				state_d   = S_IDLE;
			end
			S_RD_CHK: begin
				cmd.rd_chk = 1'b1;
				corner_d   = C_Y1X1;
				state_d    = sts.rd_err ? S_DONE : S_RD_MEM;
			end
			S_RD_MEM: begin
				cmd.rd_mem = 1'b1;
				cmd.corner = corner_q;
				corner_d   = corner_q + 2'd1;
				if (corner_q == C_Y0X0) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			corner_q <= C_Y1X1;
		end else begin
			state_q  <= state_d;
			corner_q <= corner_d;
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("a second request was taken while one was in progress");

	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q == S_CLEAR) |-> $past(sts.clr_last))
		else $error("clearing pass left before the last entry");

endmodule

>>> rtl/bbsa_dp.sv
module bbsa_dp import bbsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  cfg_ready,
	output logic                  m_tvalid,
	output logic [M_TDATA_W-1:0]  m_tdata,
	output logic                  m_tuser,
	input  logic                  m_tready,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	logic [DIM_W-1:0]    cfg_w_q, cfg_h_q;
	logic [RAD_W-1:0]    cfg_r_q;
	logic [DIM_W-1:0]    wc, hc;

	logic [COORD_W-1:0]  col_q, row_q, col_c, row_c;
	logic [DIM_W-1:0]    col_n, row_n;
	logic [ROWSUM_W-1:0] rowsum_q, rowsum_new;

	logic [PIX_W-1:0]    pix_q;
	logic [COORD_W-1:0]  x_q, y_q;
	logic [COORD_W-1:0]  x0_c, y0_c, x0_q, y0_q;
	logic [EXT_W-1:0]    xe, ye;
	logic [DIM_W-1:0]    x1_c, y1_c, x1_q, y1_q;
	logic                err_c, err_q;
	logic [DIM_W-1:0]    dx, dy;
	logic [AREA_W-1:0]   area_q;

	logic [ADDR_W-1:0]   clr_q;
	logic [ADDR_W-1:0]   ld_raddr, ld_waddr, rd_addr, raddr, waddr;
	logic [ENTRY_W-1:0]  rdata, ld_wdata, wdata;
	logic                we;

	logic                rd_vld_s1;
	logic [1:0]          corner_s1;
	logic signed [SUM_W-1:0] acc_q, acc_base, acc_add, ext;
	logic                div_start, div_done;
	logic [DVD_W-1:0]    dividend;
	logic [Q_W-1:0]      quot;

	logic                m_tvalid_q, m_err_q;
	logic [Q_W-1:0]      m_val_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= DIM_W'(MAX_WIDTH);
			cfg_h_q <= DIM_W'(MAX_HEIGHT);
			cfg_r_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:  cfg_w_q <= cfg_data;
				REG_HEIGHT: cfg_h_q <= cfg_data;
				REG_RADIUS: cfg_r_q <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// A size of zero counts as one and anything above the table counts as its limit.
	assign wc = (cfg_w_q == '0) ? DIM_W'(1) :
		(cfg_w_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_w_q;
	assign hc = (cfg_h_q == '0) ? DIM_W'(1) :
		(cfg_h_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_h_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q <= s_tdata[PIX_W-1:0];
			x_q   <= s_tdata[PIX_W +: COORD_W];
			y_q   <= s_tdata[PIX_W+COORD_W +: COORD_W];
		end
	end

	// Loading: the counters are clipped to the current size before use.
	assign col_c = (DIM_W'(col_q) > wc - DIM_W'(1)) ? COORD_W'(wc - DIM_W'(1)) : col_q;
	assign row_c = (DIM_W'(row_q) > hc - DIM_W'(1)) ? COORD_W'(hc - DIM_W'(1)) : row_q;
	assign col_n = DIM_W'(col_c) + DIM_W'(1);
	assign row_n = DIM_W'(row_c) + DIM_W'(1);
	assign rowsum_new = rowsum_q + ROWSUM_W'(pix_q);
	assign ld_raddr = addr_of(DIM_W'(row_c), col_n);
	assign ld_waddr = addr_of(row_n, col_n);
	assign ld_wdata = rdata + ENTRY_W'(rowsum_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			rowsum_q <= '0;
		end else if (cmd.ld_wr) begin
			if (col_n >= wc) begin
				col_q    <= '0;
				rowsum_q <= '0;
				row_q    <= (row_n >= hc) ? '0 : COORD_W'(row_n);
			end else begin
				col_q    <= COORD_W'(col_n);
				row_q    <= row_c;
				rowsum_q <= rowsum_new;
			end
		end
	end

	// Reading: clip the window to the image.
	assign err_c = (DIM_W'(x_q) >= wc) || (DIM_W'(y_q) >= hc);
	assign x0_c  = (x_q > COORD_W'(cfg_r_q)) ? x_q - COORD_W'(cfg_r_q) : '0;
	assign y0_c  = (y_q > COORD_W'(cfg_r_q)) ? y_q - COORD_W'(cfg_r_q) : '0;
	assign xe    = EXT_W'(x_q) + EXT_W'(cfg_r_q) + EXT_W'(1);
	assign ye    = EXT_W'(y_q) + EXT_W'(cfg_r_q) + EXT_W'(1);
	assign x1_c  = (xe > EXT_W'(wc)) ? wc : DIM_W'(xe);
	assign y1_c  = (ye > EXT_W'(hc)) ? hc : DIM_W'(ye);

	always_ff @(posedge clk) begin
		if (cmd.rd_chk) begin
			x0_q  <= x0_c;
			y0_q  <= y0_c;
			x1_q  <= x1_c;
			y1_q  <= y1_c;
			err_q <= err_c;
		end
	end

	assign dx = x1_q - DIM_W'(x0_q);
	assign dy = y1_q - DIM_W'(y0_q);

	always_ff @(posedge clk) begin
		if (cmd.rd_mem) begin
			area_q <= AREA_W'((2 * DIM_W)'(dx) * (2 * DIM_W)'(dy));
		end
	end

	always_comb begin
		unique case (cmd.corner)
			C_Y1X1: rd_addr = addr_of(y1_q, x1_q);
			C_Y0X1: rd_addr = addr_of(DIM_W'(y0_q), x1_q);
			C_Y1X0: rd_addr = addr_of(y1_q, DIM_W'(x0_q));
			C_Y0X0: rd_addr = addr_of(DIM_W'(y0_q), DIM_W'(x0_q));
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	assign we    = cmd.clr || cmd.ld_wr;
	assign waddr = cmd.clr ? clr_q : ld_waddr;
	assign wdata = cmd.clr ? '0 : ld_wdata;
	assign raddr = cmd.rd_mem ? rd_addr : ld_raddr;

	bbsa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_mem;
		end
	end

	always_ff @(posedge clk) begin
		corner_s1 <= cmd.corner;
	end

	assign ext      = $signed({{(SUM_W - ENTRY_W){1'b0}}, rdata});
	assign acc_base = (corner_s1 == C_Y1X1) ? '0 : acc_q;
	assign acc_add  = (corner_s1 == C_Y1X1 || corner_s1 == C_Y0X0) ?
		acc_base + ext : acc_base - ext;

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			acc_q <= acc_add;
		end
	end

	// A negative window sum comes only from a mixed table and counts as zero.
	assign div_start = rd_vld_s1 && (corner_s1 == C_Y0X0);
	assign dividend  = acc_add[SUM_W-1] ? '0 : acc_add[DVD_W-1:0];

	bbsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (area_q),
		.quotient (quot),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_val_q <= err_q ? '0 : quot;
			m_err_q <= err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(m_val_q);
	assign m_tuser  = m_err_q;

	assign sts.clr_last = (clr_q == ADDR_W'(DEPTH - 1));
	assign sts.rd_err   = err_c;
	assign sts.div_done = div_done;
	assign sts.out_free = !m_tvalid_q || m_tready;

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("out-of-range result carries a non-zero value");

endmodule

>>> rtl/box_blur_summed_area.sv
// Channel  Direction  Signals                                  Contents
// s        in         s_tvalid s_tready s_tdata s_tuser        one load or read request
// m        out        m_tvalid m_tready m_tdata m_tuser        blurred pixel and error flag
// cfg      in         cfg_valid cfg_ready cfg_index cfg_data   register write
//
// A load request makes one integral-table read and one write.
// A read request makes four table reads through the single read port and
// eight steps of the restoring divider; an out-of-range read skips both.
// After reset a clearing pass writes all 4225 table entries, one a cycle, before the
// first request is taken; configuration writes are taken throughout.
// A result waiting on m stalls the block only when the next read is ready to deliver.
module box_blur_summed_area import bbsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // pixel_in[7:0], read_x[13:8], read_y[19:14]
	input  logic                  s_tuser,   // req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // blurred_value[7:0]
	output logic                  m_tuser,   // range_error
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	bbsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.req_type (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bbsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
